// ----- rtl/phase_amplitude_histogram_assert.svh -----
// ---------------------------------------------------------------------------
// Phase amplitude histogram assertion macros
// Shorthand for clocked concurrent checks on clk_i, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef PHASE_AMPLITUDE_HISTOGRAM_ASSERT_SVH
`define PHASE_AMPLITUDE_HISTOGRAM_ASSERT_SVH

// same-cycle implication
`define PAH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PAH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/pah_pkg.sv -----
// ---------------------------------------------------------------------------
// pah_pkg
// Types, sizes and binning constants shared by the histogram modules.
// ---------------------------------------------------------------------------
`default_nettype none

package pah_pkg;

  localparam int unsigned PHASE_BINS  = 360;
  localparam int unsigned AMP_BINS    = 64;
  localparam int unsigned COUNT_WIDTH = 32;
  localparam int unsigned PHASE_MOD   = 360;

  localparam int unsigned TOTAL_BINS = PHASE_BINS * AMP_BINS;
  localparam int unsigned ADDR_W     = $clog2(TOTAL_BINS);

  localparam int unsigned PHASE_W = 12;
  localparam int unsigned AMP_W   = 16;
  localparam int unsigned PB_W    = 9;
  localparam int unsigned AB_W    = 6;
  localparam int unsigned CNT_W   = 32;

  // amplitude divider: dividend is offset * AMP_BINS
  localparam int unsigned DIVD_W    = AMP_W + $clog2(AMP_BINS);
  localparam int unsigned DIV_CNT_W = $clog2(DIVD_W);

  // phase window divide done as multiply by reciprocal (exact for 9-bit values)
  localparam int unsigned WINDOW     = PHASE_MOD / PHASE_BINS;
  localparam int unsigned PH_SHIFT   = 18;
  localparam int unsigned PH_RECIP   = (1 << PH_SHIFT) / WINDOW + 1;
  localparam int unsigned PH_RECIP_W = PH_SHIFT + 1;
  localparam int unsigned PH_PROD_W  = PB_W + PH_RECIP_W;

  localparam int unsigned CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AMP_MIN = 1'b0,
    REG_AMP_MAX = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NOP   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_COUNTED  = 2'd0,
    ST_REJECTED = 2'd1,
    ST_READ     = 2'd2,
    ST_CLEARED  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_DIV,
    S_BIN,
    S_RMW_RD,
    S_RMW_WR,
    S_RD,
    S_RD_DATA,
    S_CLR,
    S_DONE
  } state_e;

  typedef struct packed {
    action_e                   action;
    logic [PHASE_W-1:0]        pulse_phase;
    logic signed [AMP_W-1:0]   pulse_amplitude;
    logic [PB_W-1:0]           query_phase_bin;
    logic [AB_W-1:0]           query_amp_bin;
  } in_item_t;

  typedef struct packed {
    status_e           status;
    logic [PB_W-1:0]   phase_bin;
    logic [AB_W-1:0]   amp_bin;
    logic [CNT_W-1:0]  bin_count;
  } out_item_t;

  typedef struct packed {
    logic    capture;
    logic    div_start;
    logic    div_step;
    logic    bin_calc;
    logic    rmw_rd;
    logic    rmw_wr;
    logic    rd_query;
    logic    rd_data;
    logic    clr_step;
    logic    out_load;
    status_e out_status;
  } pah_cmd_t;

  typedef struct packed {
    action_e action;
    logic    reject;
    logic    div_last;
    logic    sweep_last;
    logic    out_free;
  } pah_sts_t;

endpackage

`default_nettype wire

// ----- rtl/phase_amplitude_histogram.sv -----
// ---------------------------------------------------------------------------
// phase_amplitude_histogram
// Phase by amplitude pulse count histogram with saturating bins.
// ---------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o/in_data_i) takes one action per
// transaction: add pulse, read one bin, clear all bins, or a no-op code that
// gives no result. Each add, read and clear returns exactly one result
// transaction on out_valid_o/out_ready_i/out_data_o.
// Config channel (cfg_*) writes amp_min / amp_max; always ready, write only
// while the block is idle.
// An add runs through the bit-serial amplitude divider and the memory
// read-modify-write before its result is valid; a rejected add skips both;
// a read does one memory read; a clear zeroes all rows, one memory row per
// cycle. One item is in flight at a time.
// After reset a clearing pass over all TOTAL_BINS (23040) rows runs with
// in_ready_o low; config writes are still taken.
// Results sit in an output register: a stalled receiver holds the result,
// and the next item can be accepted meanwhile, but its result waits.
// ---------------------------------------------------------------------------
`default_nettype none

module phase_amplitude_histogram import pah_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output      logic                 in_ready_o,
  input  wire in_item_t             in_data_i,
  output      logic                 out_valid_o,
  input  wire logic                 out_ready_i,
  output      out_item_t            out_data_o,
  input  wire logic                 cfg_valid_i,
  output      logic                 cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [AMP_W-1:0]     cfg_data_i
);

  pah_cmd_t cmd;
  pah_sts_t sts;

  assign cfg_ready_o = 1'b1;

  pah_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pah_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ----- rtl/pah_ram.sv -----
// ---------------------------------------------------------------------------
// pah_ram
// Generic single-port RAM, one access per cycle, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module pah_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/pah_datapath.sv -----
// ---------------------------------------------------------------------------
// pah_datapath
// Config registers, binning arithmetic, count memory and result register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "phase_amplitude_histogram_assert.svh"

module pah_datapath import pah_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire in_item_t             in_data_i,
  input  wire logic                 cfg_valid_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [AMP_W-1:0]     cfg_data_i,
  input  wire pah_cmd_t             cmd_i,
  output      pah_sts_t             sts_o,
  input  wire logic                 out_ready_i,
  output      logic                 out_valid_o,
  output      out_item_t            out_data_o
);

  in_item_t                in_q;
  logic signed [AMP_W-1:0] amp_min_q, amp_max_q;
  logic [PHASE_W-1:0]      ph_q;
  logic [AMP_W-1:0]        rem_q, span_q;
  logic [DIVD_W-1:0]       quo_q;
  logic [DIV_CNT_W-1:0]    div_cnt_q;
  logic [PB_W-1:0]         pb_q;
  logic [AB_W-1:0]         ab_q;
  logic [COUNT_WIDTH-1:0]  count_q;
  logic [ADDR_W-1:0]       sweep_q;
  logic                    out_valid_q;
  out_item_t               out_q;

  logic signed [AMP_W:0]   amp_x, min_x, max_x;
  logic                    reject_w;
  logic [AMP_W-1:0]        off_w, span_w;
  logic [DIVD_W-1:0]       dividend_w;
  logic [AMP_W:0]          rem_sh_w;
  logic                    ge_w;
  logic [AMP_W-1:0]        rem_nx_w;
  logic [PH_PROD_W-1:0]    ph_prod_w;
  logic [PH_PROD_W-PH_SHIFT-1:0] pb_raw_w;
  logic [PB_W-1:0]         pb_w;
  logic [AB_W-1:0]         ab_w;
  logic [ADDR_W-1:0]       bin_addr_w, query_addr_w, mem_addr_w;
  logic                    query_ok_w;
  logic                    mem_we_w;
  logic [COUNT_WIDTH-1:0]  mem_wdata_w, mem_rdata_w, inc_w;
  logic                    sweep_last_w;
  out_item_t               out_d;

  // --- amplitude range and span ---
  assign amp_x    = {in_q.pulse_amplitude[AMP_W-1], in_q.pulse_amplitude};
  assign min_x    = {amp_min_q[AMP_W-1], amp_min_q};
  assign max_x    = {amp_max_q[AMP_W-1], amp_max_q};
  assign reject_w = (amp_x < min_x) || (amp_x > max_x);
  // both non-negative and below 2^16 once the pulse is accepted
  assign off_w      = AMP_W'(amp_x - min_x);
  assign span_w     = AMP_W'(max_x - min_x);
  assign dividend_w = DIVD_W'(off_w) * DIVD_W'(AMP_BINS);

  // --- restoring divider step ---
  assign rem_sh_w = {rem_q, quo_q[DIVD_W-1]};
  assign ge_w     = rem_sh_w >= {1'b0, span_q};
  assign rem_nx_w = ge_w ? AMP_W'(rem_sh_w - {1'b0, span_q}) : rem_sh_w[AMP_W-1:0];

  // --- bin selection ---
  assign ph_prod_w = PH_PROD_W'(ph_q[PB_W-1:0]) * PH_PROD_W'(PH_RECIP);
  assign pb_raw_w  = ph_prod_w[PH_PROD_W-1:PH_SHIFT];

  always_comb begin
    if (32'(pb_raw_w) >= PHASE_BINS) begin
      pb_w = PB_W'(PHASE_BINS - 1);
    end else begin
      pb_w = pb_raw_w[PB_W-1:0];
    end
    if (span_q == '0) begin
      ab_w = '0;
    end else if (32'(quo_q) >= AMP_BINS) begin
      ab_w = AB_W'(AMP_BINS - 1);
    end else begin
      ab_w = quo_q[AB_W-1:0];
    end
  end

  assign bin_addr_w   = ADDR_W'(pb_q) * ADDR_W'(AMP_BINS) + ADDR_W'(ab_q);
  assign query_addr_w = ADDR_W'(in_q.query_phase_bin) * ADDR_W'(AMP_BINS)
                      + ADDR_W'(in_q.query_amp_bin);
  assign query_ok_w   = (32'(in_q.query_phase_bin) < PHASE_BINS)
                     && (32'(in_q.query_amp_bin) < AMP_BINS);
  assign sweep_last_w = sweep_q == ADDR_W'(TOTAL_BINS - 1);

  // --- count memory ---
  assign inc_w = (mem_rdata_w == {COUNT_WIDTH{1'b1}}) ? mem_rdata_w
                                                      : mem_rdata_w + 1'b1;

  always_comb begin
    mem_we_w    = cmd_i.clr_step || cmd_i.rmw_wr;
    mem_wdata_w = cmd_i.clr_step ? '0 : inc_w;
    priority if (cmd_i.clr_step) begin
      mem_addr_w = sweep_q;
    end else if (cmd_i.rd_query) begin
      mem_addr_w = query_addr_w;
    end else begin
      mem_addr_w = bin_addr_w;
    end
  end

  pah_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (TOTAL_BINS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we_w),
    .addr_i  (mem_addr_w),
    .wdata_i (mem_wdata_w),
    .rdata_o (mem_rdata_w)
  );

  // --- result composition ---
  always_comb begin
    out_d.status = cmd_i.out_status;
    unique case (cmd_i.out_status)
      ST_COUNTED: begin
        out_d.phase_bin = pb_q;
        out_d.amp_bin   = ab_q;
        out_d.bin_count = CNT_W'(count_q);
      end
      ST_READ: begin
        out_d.phase_bin = in_q.query_phase_bin;
        out_d.amp_bin   = in_q.query_amp_bin;
        out_d.bin_count = CNT_W'(count_q);
      end
      default: begin
        out_d.phase_bin = '0;
        out_d.amp_bin   = '0;
        out_d.bin_count = '0;
      end
    endcase
  end

  // --- control-side registers ---
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amp_min_q   <= '0;
      amp_max_q   <= AMP_W'(100);
      sweep_q     <= '0;
      out_valid_q <= 1'b0;
      div_cnt_q   <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_AMP_MIN: amp_min_q <= cfg_data_i;
          REG_AMP_MAX: amp_max_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.clr_step) begin
        sweep_q <= sweep_last_w ? '0 : sweep_q + 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.div_start) begin
        div_cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q + 1'b1;
      end
    end
  end

  // --- payload registers ---
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_q <= in_data_i;
    end
    if (cmd_i.div_start) begin
      ph_q   <= in_q.pulse_phase;
      rem_q  <= '0;
      quo_q  <= dividend_w;
      span_q <= span_w;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_nx_w;
      quo_q <= {quo_q[DIVD_W-2:0], ge_w};
      // phase mod 360 runs alongside, one subtraction per step
      if (ph_q >= PHASE_W'(PHASE_MOD)) begin
        ph_q <= ph_q - PHASE_W'(PHASE_MOD);
      end
    end
    if (cmd_i.bin_calc) begin
      pb_q <= pb_w;
      ab_q <= ab_w;
    end
    if (cmd_i.rmw_wr) begin
      count_q <= inc_w;
    end else if (cmd_i.rd_data) begin
      count_q <= query_ok_w ? mem_rdata_w : '0;
    end
    if (cmd_i.out_load) begin
      out_q <= out_d;
    end
  end

  assign sts_o.action     = in_q.action;
  assign sts_o.reject     = reject_w;
  assign sts_o.div_last   = div_cnt_q == DIV_CNT_W'(DIVD_W - 1);
  assign sts_o.sweep_last = sweep_last_w;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `PAH_ASSERT_IMP(a_phase_reduced, cmd_i.bin_calc, ph_q < PHASE_W'(PHASE_MOD), "phase not reduced")
  `PAH_ASSERT_NXT(a_sweep_wraps, cmd_i.clr_step && sweep_last_w, sweep_q == '0, "sweep no wrap")
  `PAH_ASSERT_IMP(a_load_free, cmd_i.out_load, !out_valid_q || out_ready_i, "result overwritten")
  `PAH_ASSERT_IMP(a_wr_after_rd, cmd_i.rmw_wr, $past(cmd_i.rmw_rd), "increment without read")

endmodule

`default_nettype wire

// ----- rtl/pah_ctrl.sv -----
// ---------------------------------------------------------------------------
// pah_ctrl
// Sequencer: clearing pass, add/read/clear flows and result handoff.
// ---------------------------------------------------------------------------
`default_nettype none

module pah_ctrl import pah_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output      logic     in_ready_o,
  input  wire pah_sts_t sts_i,
  output      pah_cmd_t cmd_o
);

  state_e  state_q, state_d;
  status_e res_q, res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      res_q   <= ST_COUNTED;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    unique case (state_q)
      S_INIT: if (sts_i.sweep_last) state_d = S_IDLE;
      S_IDLE: if (in_valid_i) state_d = S_DECODE;
      S_DECODE: begin
        unique case (sts_i.action)
          ACT_ADD: begin
            if (sts_i.reject) begin
              res_d   = ST_REJECTED;
              state_d = S_DONE;
            end else begin
              res_d   = ST_COUNTED;
              state_d = S_DIV;
            end
          end
          ACT_READ: begin
            res_d   = ST_READ;
            state_d = S_RD;
          end
          ACT_CLEAR: begin
            res_d   = ST_CLEARED;
            state_d = S_CLR;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_DIV:     if (sts_i.div_last) state_d = S_BIN;
      S_BIN:     state_d = S_RMW_RD;
      S_RMW_RD:  state_d = S_RMW_WR;
      S_RMW_WR:  state_d = S_DONE;
      S_RD:      state_d = S_RD_DATA;
      S_RD_DATA: state_d = S_DONE;
      S_CLR:     if (sts_i.sweep_last) state_d = S_DONE;
      S_DONE:    if (sts_i.out_free) state_d = S_IDLE;
      default:   state_d = S_INIT;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o            = '0;
    cmd_o.out_status = res_q;
    in_ready_o       = 1'b0;
    unique case (state_q)
      S_INIT: cmd_o.clr_step = 1'b1;
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      S_DECODE:  cmd_o.div_start = (sts_i.action == ACT_ADD);
      S_DIV:     cmd_o.div_step  = 1'b1;
      S_BIN:     cmd_o.bin_calc  = 1'b1;
      S_RMW_RD:  cmd_o.rmw_rd    = 1'b1;
      S_RMW_WR:  cmd_o.rmw_wr    = 1'b1;
      S_RD:      cmd_o.rd_query  = 1'b1;
      S_RD_DATA: cmd_o.rd_data   = 1'b1;
      S_CLR:     cmd_o.clr_step  = 1'b1;
      S_DONE:    cmd_o.out_load  = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire
